// ----- src/sfr_pkg.sv -----
`default_nettype none

package sfr_pkg;

    localparam int NUM_SLOTS          = 8;
    localparam int FRAME_BUFFER_DEPTH = 64;
    localparam int MIN_FRAME_LENGTH   = 15;

    localparam logic [7:0] HDR_BYTE = 8'hA5;
    localparam logic [7:0] FTR_BYTE = 8'h5A;
    localparam logic [7:0] CMD_DATA = 8'h02;
    localparam logic [31:0] UNUSED_ID = 32'h0000_0000;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam int KEEP_BYTES = 12;
    localparam int KEEP_IDX_W = $clog2(KEEP_BYTES);

    localparam int CNT_W = $clog2(FRAME_BUFFER_DEPTH);
    localparam int MIN_W = $clog2(MIN_FRAME_LENGTH + 1);
    localparam int CMP_W = (CNT_W + 1 > MIN_W) ? CNT_W + 1 : MIN_W;

    localparam int CFG_IDX_W  = 3;
    localparam int SLOT_IDX_W = 3;
    localparam int MASK_W     = 8;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic                    frame_closed;
        logic                    data_accepted;
        logic                    slot_matched;
        logic [SLOT_IDX_W-1:0]   slot_index;
        logic [31:0]             node_id;
        logic signed [15:0]      temperature_raw;
        logic signed [15:0]      humidity_raw;
        logic signed [7:0]       link_rssi;
        logic [7:0]              battery_level;
        logic [MASK_W-1:0]       received_mask;
        logic                    all_received;
    } t_result;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_CLOSE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               data_accepted;
        logic [31:0]        node_id;
        logic signed [15:0] temperature_raw;
        logic signed [15:0] humidity_raw;
        logic signed [7:0]  link_rssi;
        logic [7:0]         battery_level;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd entry;
    } t_cmd_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_cmd_status;

endpackage

`default_nettype wire

// ----- src/sensor_frame_receiver.sv -----
// Sensor frame receiver: collects link bytes into frames and reports one result per item.
// Input channel: drive i_in and raise push; a transfer happens on a clock edge with push
// high and full low. operation 0 carries one received byte, operation 1 clears the
// received marks and the frame fill.
// Result channel: while empty is low the oldest result sits on o_result; raise pop to
// take it. Every input transfer yields exactly one result, in order.
// Configuration: write slot device ids through i_cfg_valid / i_cfg_index / i_cfg_data;
// o_cfg_ready is always high. Write only while no results are outstanding.
// Path: an input transfer is written into the command queue; the back end pops it from
// there and registers its result into the result queue that drives o_result.
// Throughput: one item per cycle while results drain, set by the combinational slot compare.
// A two-entry command queue sits between the byte parser and the slot matcher, and a
// two-entry result queue sits at the output, so a stalled receiver backs up into full
// only after both queues fill.
// Reset (synchronous, active low) empties both queues, zeroes the fill count, clears
// the received marks and sets all slot ids to zero.
`default_nettype none

module sensor_frame_receiver (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  sfr_pkg::t_in_item            i_in,
    output logic                         empty,
    input  wire                          pop,
    output sfr_pkg::t_result             o_result,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [31:0]                   i_cfg_data
);

    sfr_pkg::t_cmd_wr     front_wr;
    sfr_pkg::t_cmd        cq_head;
    sfr_pkg::t_cmd_status cq_status;
    logic                 cq_pop;
    logic                 accept;

    assign full        = cq_status.full;
    assign accept      = push && !cq_status.full;
    assign o_cfg_ready = 1'b1;

    sfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_in    (i_in),
        .o_wr    (front_wr)
    );

    sfr_cmd_queue u_cq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (front_wr),
        .i_pop    (cq_pop),
        .o_head   (cq_head),
        .o_status (cq_status)
    );

    sfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (cq_head),
        .i_cq_status (cq_status),
        .o_cq_pop    (cq_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ----- src/sfr_front.sv -----
`default_nettype none

module sfr_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  sfr_pkg::t_in_item   i_in,
    output sfr_pkg::t_cmd_wr    o_wr
);

    logic [sfr_pkg::CNT_W-1:0] r_fill;
    logic [sfr_pkg::CNT_W-1:0] n_fill;
    logic [7:0]                r_frame [sfr_pkg::KEEP_BYTES];

    logic [sfr_pkg::CNT_W:0]   inc;
    logic                      collect;
    logic                      store;
    logic                      close;

    always_comb begin
        inc     = {1'b0, r_fill} + {{sfr_pkg::CNT_W{1'b0}}, 1'b1};
        collect = !i_in.operation && !(r_fill == '0 && i_in.rx_byte != sfr_pkg::HDR_BYTE);
        store   = collect && ({1'b0, r_fill} < (sfr_pkg::CNT_W + 1)'(sfr_pkg::KEEP_BYTES));
        close   = collect && (i_in.rx_byte == sfr_pkg::FTR_BYTE) &&
                  (sfr_pkg::CMP_W'(inc) >= sfr_pkg::CMP_W'(sfr_pkg::MIN_FRAME_LENGTH));

        n_fill = r_fill;
        if (i_in.operation) begin
            n_fill = '0;
        end else if (collect) begin
            if (close || inc == (sfr_pkg::CNT_W + 1)'(sfr_pkg::FRAME_BUFFER_DEPTH)) begin
                n_fill = '0;
            end else begin
                n_fill = inc[sfr_pkg::CNT_W-1:0];
            end
        end

        o_wr.push  = i_push;
        o_wr.entry = '0;
        if (i_in.operation) begin
            o_wr.entry.kind = sfr_pkg::CMD_CLEAR;
        end else if (close) begin
            o_wr.entry.kind = sfr_pkg::CMD_CLOSE;
            if (r_frame[1] == sfr_pkg::CMD_DATA) begin
                o_wr.entry.data_accepted   = 1'b1;
                o_wr.entry.node_id         = {r_frame[2], r_frame[3], r_frame[4], r_frame[5]};
                o_wr.entry.temperature_raw = {r_frame[6], r_frame[7]};
                o_wr.entry.humidity_raw    = {r_frame[8], r_frame[9]};
                o_wr.entry.link_rssi       = r_frame[10];
                o_wr.entry.battery_level   = r_frame[11];
            end
        end else begin
            o_wr.entry.kind = sfr_pkg::CMD_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_push) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && store) begin
            r_frame[r_fill[sfr_pkg::KEEP_IDX_W-1:0]] <= i_in.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ----- src/sfr_cmd_queue.sv -----
`default_nettype none

module sfr_cmd_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  sfr_pkg::t_cmd_wr     i_wr,
    input  wire                  i_pop,
    output sfr_pkg::t_cmd        o_head,
    output sfr_pkg::t_cmd_status o_status
);

    sfr_pkg::t_cmd                r_mem [sfr_pkg::CQ_DEPTH];
    logic [sfr_pkg::CQ_PTR_W-1:0] r_wr_ptr;
    logic [sfr_pkg::CQ_PTR_W-1:0] r_rd_ptr;
    logic [sfr_pkg::CQ_CNT_W-1:0] r_cnt;
    logic                         wr_en;
    logic                         rd_en;

    assign o_status.full  = (r_cnt == sfr_pkg::CQ_CNT_W'(sfr_pkg::CQ_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign wr_en  = i_wr.push && !o_status.full;
    assign rd_en  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr.entry;
        end
    end

endmodule

`default_nettype wire

// ----- src/sfr_back.sv -----
`default_nettype none

module sfr_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    input  wire [sfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [31:0]                       i_cfg_data,
    input  sfr_pkg::t_cmd                    i_head,
    input  sfr_pkg::t_cmd_status             i_cq_status,
    output logic                             o_cq_pop,
    output logic                             o_empty,
    input  wire                              i_pop,
    output sfr_pkg::t_result                 o_result
);

    logic [31:0]                  r_slot_id [sfr_pkg::NUM_SLOTS];
    logic [sfr_pkg::MASK_W-1:0]   r_flags;
    logic [sfr_pkg::MASK_W-1:0]   n_flags;

    sfr_pkg::t_result             r_oq [sfr_pkg::OQ_DEPTH];
    logic [sfr_pkg::OQ_PTR_W-1:0] r_wr_ptr;
    logic [sfr_pkg::OQ_PTR_W-1:0] r_rd_ptr;
    logic [sfr_pkg::OQ_CNT_W-1:0] r_cnt;

    sfr_pkg::t_result             res;
    logic                         hit;
    logic [sfr_pkg::SLOT_IDX_W-1:0] hit_idx;
    logic                         all_done;
    logic                         rd_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sfr_pkg::NUM_SLOTS; i++) begin
                r_slot_id[i] <= sfr_pkg::UNUSED_ID;
            end
        end else if (i_cfg_valid &&
                     ({1'b0, i_cfg_index} < (sfr_pkg::CFG_IDX_W + 1)'(sfr_pkg::NUM_SLOTS))) begin
            r_slot_id[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = sfr_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_id[i] == i_head.node_id) begin
                hit     = 1'b1;
                hit_idx = sfr_pkg::SLOT_IDX_W'(i);
            end
        end

        res = '0;
        n_flags = r_flags;
        unique case (i_head.kind)
            sfr_pkg::CMD_CLEAR: begin
                n_flags = '0;
            end
            sfr_pkg::CMD_CLOSE: begin
                res.frame_closed = 1'b1;
                if (i_head.data_accepted) begin
                    res.data_accepted   = 1'b1;
                    res.slot_matched    = hit;
                    res.slot_index      = hit_idx;
                    res.node_id         = i_head.node_id;
                    res.temperature_raw = i_head.temperature_raw;
                    res.humidity_raw    = i_head.humidity_raw;
                    res.link_rssi       = i_head.link_rssi;
                    res.battery_level   = i_head.battery_level;
                    if (hit) begin
                        n_flags[hit_idx] = 1'b1;
                    end
                end
            end
            default: begin
                n_flags = r_flags;
            end
        endcase

        all_done = 1'b1;
        for (int i = 0; i < sfr_pkg::NUM_SLOTS; i++) begin
            if (r_slot_id[i] != sfr_pkg::UNUSED_ID && !n_flags[i]) begin
                all_done = 1'b0;
            end
        end
        res.received_mask = n_flags;
        res.all_received  = all_done;
    end

    assign o_cq_pop = !i_cq_status.empty && (r_cnt != sfr_pkg::OQ_CNT_W'(sfr_pkg::OQ_DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign rd_en    = i_pop && !o_empty;
    assign o_result = r_oq[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (o_cq_pop) begin
                r_flags  <= n_flags;
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (o_cq_pop && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !o_cq_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cq_pop) begin
            r_oq[r_wr_ptr] <= res;
        end
    end

endmodule

`default_nettype wire

// ----- src/sfr_checker.sv -----
`default_nettype none

module sfr_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              full,
    input wire              empty,
    input sfr_pkg::t_result o_result
);

    property p_reset_clears;
        @(posedge i_clk) !i_rst_n |=> (!full && empty);
    endproperty
    a_reset_clears: assert property (p_reset_clears)
        else $error("queues not empty after reset");

    property p_data_needs_close;
        @(posedge i_clk) disable iff (!i_rst_n)
            (!empty && o_result.data_accepted) |-> o_result.frame_closed;
    endproperty
    a_data_needs_close: assert property (p_data_needs_close)
        else $error("data accepted without frame close");

    property p_match_needs_data;
        @(posedge i_clk) disable iff (!i_rst_n)
            (!empty && o_result.slot_matched) |-> o_result.data_accepted;
    endproperty
    a_match_needs_data: assert property (p_match_needs_data)
        else $error("slot match without data frame");

    property p_match_marks_slot;
        @(posedge i_clk) disable iff (!i_rst_n)
            (!empty && o_result.slot_matched) |->
                o_result.received_mask[o_result.slot_index];
    endproperty
    a_match_marks_slot: assert property (p_match_marks_slot)
        else $error("matched slot not marked received");

    property p_no_data_zero_fields;
        @(posedge i_clk) disable iff (!i_rst_n)
            (!empty && !o_result.data_accepted) |->
                (o_result.node_id == '0 && o_result.slot_index == '0 &&
                 o_result.battery_level == '0);
    endproperty
    a_no_data_zero_fields: assert property (p_no_data_zero_fields)
        else $error("payload fields set on a non-data result");

endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .o_result (o_result)
);

`default_nettype wire

// ----- bench/sensor_frame_receiver_chk.sv -----
`timescale 1ns / 100ps

module sensor_frame_receiver_chk (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    input  wire                           i_full,
    input  sfr_pkg::t_in_item             i_in,
    input  wire                           i_empty,
    input  wire                           i_pop,
    input  sfr_pkg::t_result              i_result,
    input  wire                           i_cfg_valid,
    input  wire                           i_cfg_ready,
    input  wire [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [31:0]                    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    logic [31:0]                slot_id [sfr_pkg::NUM_SLOTS];
    logic [7:0]                 frame_byte [sfr_pkg::KEEP_BYTES];
    int unsigned                fill;
    logic [sfr_pkg::MASK_W-1:0] marks;
    sfr_pkg::t_result           predicted_reports [$];
    int                         fails = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
        end
    endtask

    function automatic logic all_marked();
        for (int i = 0; i < sfr_pkg::NUM_SLOTS; i++) begin
            if (slot_id[i] != sfr_pkg::UNUSED_ID && !marks[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic sfr_pkg::t_result receive_item(input sfr_pkg::t_in_item item);
        sfr_pkg::t_result r;
        logic [31:0]      id;
        r = '0;
        if (item.operation == sfr_pkg::OP_CLEAR) begin
            marks = '0;
            fill  = 0;
        end else if (fill != 0 || item.rx_byte == sfr_pkg::HDR_BYTE) begin
            if (fill < sfr_pkg::KEEP_BYTES) begin
                frame_byte[fill] = item.rx_byte;
            end
            fill++;
            if (item.rx_byte == sfr_pkg::FTR_BYTE && fill >= sfr_pkg::MIN_FRAME_LENGTH) begin
                r.frame_closed = 1'b1;
                if (frame_byte[1] == sfr_pkg::CMD_DATA) begin
                    id = {frame_byte[2], frame_byte[3], frame_byte[4], frame_byte[5]};
                    r.data_accepted = 1'b1;
                    for (int i = 0; i < sfr_pkg::NUM_SLOTS; i++) begin
                        if (!r.slot_matched && slot_id[i] == id) begin
                            r.slot_matched = 1'b1;
                            r.slot_index   = sfr_pkg::SLOT_IDX_W'(i);
                            marks[i]       = 1'b1;
                        end
                    end
                    r.node_id         = id;
                    r.temperature_raw = {frame_byte[6], frame_byte[7]};
                    r.humidity_raw    = {frame_byte[8], frame_byte[9]};
                    r.link_rssi       = frame_byte[10];
                    r.battery_level   = frame_byte[11];
                end
                fill = 0;
            end
            if (fill >= sfr_pkg::FRAME_BUFFER_DEPTH) begin
                fill = 0;
            end
        end
        r.received_mask = marks;
        r.all_received  = all_marked();
        return r;
    endfunction

    always @(posedge i_clk) begin
        sfr_pkg::t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < sfr_pkg::NUM_SLOTS; i++) begin
                slot_id[i] = sfr_pkg::UNUSED_ID;
            end
            fill  = 0;
            marks = '0;
            predicted_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                slot_id[i_cfg_index] = i_cfg_data;
            end
            if (i_pop && !i_empty) begin
                if (predicted_reports.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding");
                end else begin
                    want = predicted_reports.pop_front();
                    check_field("frame_closed", i_result.frame_closed, want.frame_closed);
                    check_field("data_accepted", i_result.data_accepted,
                                want.data_accepted);
                    check_field("slot_matched", i_result.slot_matched, want.slot_matched);
                    check_field("slot_index", i_result.slot_index, want.slot_index);
                    check_field("node_id", i_result.node_id, want.node_id);
                    check_field("temperature_raw", i_result.temperature_raw,
                                want.temperature_raw);
                    check_field("humidity_raw", i_result.humidity_raw, want.humidity_raw);
                    check_field("link_rssi", i_result.link_rssi, want.link_rssi);
                    check_field("battery_level", i_result.battery_level,
                                want.battery_level);
                    check_field("received_mask", i_result.received_mask,
                                want.received_mask);
                    check_field("all_received", i_result.all_received, want.all_received);
                end
            end
            if (i_push && !i_full) begin
                predicted_reports.push_back(receive_item(i_in));
            end
        end
        o_pending    <= predicted_reports.size();
        o_fail_count <= fails;
    end

endmodule

// ----- bench/sensor_frame_receiver_tb.sv -----
`timescale 1ns / 100ps

module sensor_frame_receiver_tb;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 10;
    localparam int LIMIT_NS      = 500_000;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          push      = 1'b0;
    logic                          full;
    sfr_pkg::t_in_item             in_item   = '0;
    logic                          empty;
    logic                          pop       = 1'b0;
    sfr_pkg::t_result              result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data  = '0;
    int                            fail_count;
    int                            pending;

    logic        calm     = 1'b0;
    logic        hold_req = 1'b0;
    int          sent     = 0;
    logic [31:0] slot_cfg [sfr_pkg::NUM_SLOTS];

    sensor_frame_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_in        (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sensor_frame_receiver_chk frame_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in         (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    initial begin
        #(LIMIT_NS);
        $display("sensor_frame_receiver_tb: done, errors");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        wait (rst_n);
        forever begin
            if (hold_req) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end else begin
                pop = 1'b1;
                @(negedge clk);
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 9))
            7: return sfr_pkg::UNUSED_ID;
            8, 9: return $urandom;
            default: return slot_cfg[$urandom_range(0, sfr_pkg::NUM_SLOTS - 1)];
        endcase
    endfunction

    function automatic int frame_len();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(sfr_pkg::MIN_FRAME_LENGTH, sfr_pkg::FRAME_BUFFER_DEPTH);
        end
        return $urandom_range(sfr_pkg::MIN_FRAME_LENGTH, sfr_pkg::MIN_FRAME_LENGTH + 5);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] value);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        push    = 1'b1;
        in_item = '{operation: op, rx_byte: value};
        @(posedge clk);
        while (full) @(posedge clk);
        sent++;
    endtask

    task automatic send_bytes(input logic [7:0] seq [$]);
        foreach (seq[i]) begin
            send_item(sfr_pkg::OP_RECEIVE, seq[i]);
        end
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [31:0] id, input int len,
                              input logic close);
        logic [7:0] seq [$];
        logic [7:0] b;
        seq = {sfr_pkg::HDR_BYTE, cmd, id[31:24], id[23:16], id[15:8], id[7:0]};
        repeat (sfr_pkg::KEEP_BYTES - 6) seq.push_back(pick_byte());
        while (seq.size() < len) begin
            case ($urandom_range(0, 3))
                0: b = sfr_pkg::HDR_BYTE;
                1: b = sfr_pkg::FTR_BYTE;
                default: b = pick_byte();
            endcase
            // keep the footer out of the closing range
            if (b == sfr_pkg::FTR_BYTE && seq.size() >= sfr_pkg::MIN_FRAME_LENGTH - 1) begin
                b = ~b;
            end
            seq.push_back(b);
        end
        if (close) begin
            seq[len - 1] = sfr_pkg::FTR_BYTE;
        end else if (seq.size() > len) begin
            seq = seq[0:len - 1];
        end
        send_bytes(seq);
    endtask

    task automatic run_traffic(input int items);
        int         stop;
        logic [7:0] b;
        stop = sent + items;
        while (sent < stop) begin
            case ($urandom_range(0, 24))
                0: send_frame(pick_byte(), pick_id(), sfr_pkg::FRAME_BUFFER_DEPTH, 1'b0);
                1, 2: begin
                    send_frame(sfr_pkg::CMD_DATA, pick_id(),
                               $urandom_range(1, sfr_pkg::MIN_FRAME_LENGTH - 2), 1'b0);
                    send_item(sfr_pkg::OP_CLEAR, pick_byte());
                end
                3: begin
                    repeat ($urandom_range(1, 4)) begin
                        b = pick_byte();
                        if (b == sfr_pkg::HDR_BYTE) begin
                            b = ~b;
                        end
                        send_item(sfr_pkg::OP_RECEIVE, b);
                    end
                end
                4: send_item(sfr_pkg::OP_CLEAR, pick_byte());
                5, 6: begin
                    b = pick_byte();
                    if (b == sfr_pkg::CMD_DATA) begin
                        b = ~b;
                    end
                    send_frame(b, pick_id(), frame_len(), 1'b1);
                end
                default: send_frame(sfr_pkg::CMD_DATA, pick_id(), frame_len(), 1'b1);
            endcase
        end
    endtask

    task automatic write_slots();
        for (int i = 0; i < sfr_pkg::NUM_SLOTS; i++) begin
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = sfr_pkg::CFG_IDX_W'(i);
            cfg_data  = slot_cfg[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        logic [7:0] probe_frame [$];
        slot_cfg = '{32'hFFFF_FFFF, sfr_pkg::UNUSED_ID, 32'h0000_0001, $urandom,
                     32'h0000_0001, $urandom, sfr_pkg::UNUSED_ID, 32'h8000_0000};
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        write_slots();

        send_item(sfr_pkg::OP_RECEIVE, 8'h00);
        send_item(sfr_pkg::OP_RECEIVE, 8'hFF);
        send_item(sfr_pkg::OP_CLEAR, 8'hFF);
        probe_frame = {sfr_pkg::HDR_BYTE, sfr_pkg::CMD_DATA, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'hFF, sfr_pkg::FTR_BYTE,
                       sfr_pkg::HDR_BYTE, sfr_pkg::FTR_BYTE};
        send_bytes(probe_frame);
        send_item(sfr_pkg::OP_CLEAR, 8'h00);
        drain();

        hold_req = 1'b1;
        run_traffic(110);
        drain();

        foreach (slot_cfg[i]) begin
            slot_cfg[i] = sfr_pkg::UNUSED_ID;
        end
        write_slots();
        send_frame(sfr_pkg::CMD_DATA, sfr_pkg::UNUSED_ID, sfr_pkg::MIN_FRAME_LENGTH, 1'b1);
        send_frame(pick_byte(), pick_id(), sfr_pkg::FRAME_BUFFER_DEPTH, 1'b0);
        run_traffic(80);
        drain();

        foreach (slot_cfg[i]) begin
            slot_cfg[i] = $urandom;
            if (slot_cfg[i] == sfr_pkg::UNUSED_ID) begin
                slot_cfg[i] = 32'h0000_0001;
            end
        end
        slot_cfg[sfr_pkg::NUM_SLOTS - 1] = 32'hFFFF_FFFF;
        write_slots();
        hold_req = 1'b1;
        run_traffic(110);
        drain();

        foreach (slot_cfg[i]) begin
            slot_cfg[i] = (i < 3) ? 32'($urandom) | 32'h1 : sfr_pkg::UNUSED_ID;
        end
        calm = 1'b1;
        write_slots();
        run_traffic(110);
        drain();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("sensor_frame_receiver_tb: done, clean");
        end else begin
            $display("sensor_frame_receiver_tb: done, errors");
        end
        $finish;
    end

endmodule
